// ===== sv/spm_pkg.sv =====
// Shared types and constants for the site power and environment alarm monitor.
package spm_pkg;

  // AC averaging window; depth is a power of two so the mean is a shift.
  localparam int unsigned AVG_LOG2  = 3;
  localparam int unsigned AVG_DEPTH = 1 << AVG_LOG2;
  localparam int unsigned SLOT_W    = AVG_LOG2;
  localparam int unsigned ACC_W     = 10 + AVG_LOG2;

  // Q16 volt conversion constants.
  localparam int unsigned PROD_W    = 26;
  localparam logic [PROD_W-1:0] DC_OFS  = 26'd144179;
  localparam logic [15:0]       DC_GAIN = 16'd51898;
  localparam logic [PROD_W-1:0] AC_OFS  = 26'd159423;
  localparam logic [15:0]       AC_GAIN = 16'd22452;

  // Stream widths.
  localparam int unsigned IN_TDATA_W  = 64;
  localparam int unsigned OUT_TDATA_W = 32;

  // Config port.
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DAT_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WATER_LIMIT     = 3'd0,
    REG_DC_LOW_LIMIT    = 3'd1,
    REG_AC_LOW_LIMIT    = 3'd2,
    REG_TEMP_WARN_LIMIT = 3'd3,
    REG_TEMP_HIGH_LIMIT = 3'd4,
    REG_HUMID_LIMIT     = 3'd5
  } cfg_reg_e;

  localparam logic [9:0]         WATER_LIMIT_RST = 10'd1000;
  localparam logic [9:0]         DC_LOW_RST      = 10'd430;
  localparam logic [8:0]         AC_LOW_RST      = 9'd180;
  localparam logic signed [15:0] TEMP_WARN_RST   = 16'sd250;
  localparam logic signed [15:0] TEMP_HIGH_RST   = 16'sd600;
  localparam logic [9:0]         HUMID_LIMIT_RST = 10'd800;

  typedef struct packed {
    logic [9:0]         water_limit;
    logic [9:0]         dc_low_limit;
    logic [8:0]         ac_low_limit;
    logic signed [15:0] temp_warn_limit;
    logic signed [15:0] temp_high_limit;
    logic [9:0]         humid_limit;
  } cfg_t;

  typedef struct packed {
    logic [9:0]         water_sample;
    logic [9:0]         ac_sample;
    logic [9:0]         dc_sample;
    logic               smoke_seen;
    logic signed [15:0] temperature;
    logic [9:0]         humidity;
  } in_item_t;

  // Item held in the input register, with the AC mean it sees.
  typedef struct packed {
    logic [9:0]         water_sample;
    logic [9:0]         dc_sample;
    logic               smoke_seen;
    logic signed [15:0] temperature;
    logic [9:0]         humidity;
    logic [9:0]         ac_average;
  } stage_item_t;

  typedef struct packed {
    logic humid;
    logic hot;
    logic warm;
    logic smoke;
    logic ac_low;
    logic dc_low;
    logic water;
  } alarm_flags_t;

  typedef struct packed {
    logic [9:0]   dc_volts;
    logic [8:0]   ac_volts;
    alarm_flags_t flags;
    logic         new_alert;
  } result_t;

  // Stage-to-stage handshake.
  typedef struct packed {
    logic valid;
    logic advance;
  } stage_ctl_t;

endpackage

// ===== sv/spm_cfg_regs.sv =====
// Configuration limit registers with write port.
module spm_cfg_regs (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [spm_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [spm_pkg::CFG_DAT_W-1:0]   cfg_wdata_i,
  output spm_pkg::cfg_t                   cfg_o
);
  import spm_pkg::*;

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_WATER_LIMIT:     cfg_d.water_limit     = cfg_wdata_i[9:0];
        REG_DC_LOW_LIMIT:    cfg_d.dc_low_limit    = cfg_wdata_i[9:0];
        REG_AC_LOW_LIMIT:    cfg_d.ac_low_limit    = cfg_wdata_i[8:0];
        REG_TEMP_WARN_LIMIT: cfg_d.temp_warn_limit = $signed(cfg_wdata_i[15:0]);
        REG_TEMP_HIGH_LIMIT: cfg_d.temp_high_limit = $signed(cfg_wdata_i[15:0]);
        REG_HUMID_LIMIT:     cfg_d.humid_limit     = cfg_wdata_i[9:0];
        default:             cfg_d = cfg_q;  // unused index, ignored
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.water_limit     <= WATER_LIMIT_RST;
      cfg_q.dc_low_limit    <= DC_LOW_RST;
      cfg_q.ac_low_limit    <= AC_LOW_RST;
      cfg_q.temp_warn_limit <= TEMP_WARN_RST;
      cfg_q.temp_high_limit <= TEMP_HIGH_RST;
      cfg_q.humid_limit     <= HUMID_LIMIT_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== sv/spm_in_stage.sv =====
// Input register stage with AC window accumulator and mean latch.
module spm_in_stage (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  spm_pkg::in_item_t    item_i,
  input  logic                 advance_i,
  output logic                 valid_o,
  output spm_pkg::stage_item_t stage_o
);
  import spm_pkg::*;

  logic                    valid_q, valid_d;
  stage_item_t             stage_q;
  logic [SLOT_W-1:0]       slot_q, slot_d;
  logic [ACC_W-1:0]        acc_q, acc_d;
  logic [9:0]              avg_q, avg_d;
  logic [ACC_W-1:0]        sum;
  logic                    accept;
  logic                    last_slot;

  assign s_tready  = !valid_q || advance_i;
  assign accept    = s_tvalid && s_tready;
  assign last_slot = (slot_q == SLOT_W'(AVG_DEPTH - 1));

  // Every slot is rewritten before each latch, so a running sum equals
  // the window sum.
  assign sum = acc_q + ACC_W'(item_i.ac_sample);

  always_comb begin
    slot_d = slot_q;
    acc_d  = acc_q;
    avg_d  = avg_q;
    if (accept) begin
      if (last_slot) begin
        slot_d = '0;
        acc_d  = '0;
        avg_d  = sum[ACC_W-1:AVG_LOG2];
      end else begin
        slot_d = slot_q + SLOT_W'(1);
        acc_d  = sum;
      end
    end
    if (accept)         valid_d = 1'b1;
    else if (advance_i) valid_d = 1'b0;
    else                valid_d = valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      slot_q  <= '0;
      acc_q   <= '0;
      avg_q   <= '0;
    end else begin
      valid_q <= valid_d;
      slot_q  <= slot_d;
      acc_q   <= acc_d;
      avg_q   <= avg_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      stage_q.water_sample <= item_i.water_sample;
      stage_q.dc_sample    <= item_i.dc_sample;
      stage_q.smoke_seen   <= item_i.smoke_seen;
      stage_q.temperature  <= item_i.temperature;
      stage_q.humidity     <= item_i.humidity;
      stage_q.ac_average   <= avg_d;
    end
  end

  assign valid_o = valid_q;
  assign stage_o = stage_q;

`ifndef SYNTHESIS
  a_full_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && !advance_i) |-> !s_tready)
    else $error("input stage took a transfer while holding an item");

  a_wrap_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && last_slot) |=> (slot_q == '0 && acc_q == '0))
    else $error("AC window did not restart after the mean latch");
`endif

endmodule

// ===== sv/spm_eval.sv =====
// Volt conversion, alarm update and result register.
module spm_eval (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  spm_pkg::stage_ctl_t  ctl_i,
  input  spm_pkg::stage_item_t stage_i,
  input  spm_pkg::cfg_t        cfg_i,
  input  logic                 m_tready,
  output logic                 m_tvalid,
  output spm_pkg::result_t     result_o
);
  import spm_pkg::*;

  logic              out_valid_q, out_valid_d;
  alarm_flags_t      flags_q, flags_d;
  logic [9:0]        dcv_q, dcv_d;
  logic [8:0]        acv_q, acv_d;
  logic              alert_q, alert_d;
  logic [PROD_W-1:0] dc_prod, ac_prod;
  logic              water_lt, water_gt, dc_lt, dc_gt, ac_lt, ac_gt;

  assign dc_prod = DC_OFS + PROD_W'(DC_GAIN * PROD_W'(stage_i.dc_sample));
  assign ac_prod = AC_OFS + PROD_W'(AC_GAIN * PROD_W'(stage_i.ac_average));
  assign dcv_d   = dc_prod[25:16];
  assign acv_d   = ac_prod[24:16];

  assign water_lt = stage_i.water_sample < cfg_i.water_limit;
  assign water_gt = stage_i.water_sample > cfg_i.water_limit;
  assign dc_lt    = dcv_d < cfg_i.dc_low_limit;
  assign dc_gt    = dcv_d > cfg_i.dc_low_limit;
  assign ac_lt    = acv_d < cfg_i.ac_low_limit;
  assign ac_gt    = acv_d > cfg_i.ac_low_limit;

  always_comb begin
    flags_d = flags_q;
    // hysteresis: set below, clear above, hold on equal
    if (water_lt)      flags_d.water = 1'b1;
    else if (water_gt) flags_d.water = 1'b0;
    if (dc_lt)         flags_d.dc_low = 1'b1;
    else if (dc_gt)    flags_d.dc_low = 1'b0;
    if (ac_lt)         flags_d.ac_low = 1'b1;
    else if (ac_gt)    flags_d.ac_low = 1'b0;
    flags_d.smoke = stage_i.smoke_seen;
    flags_d.warm  = stage_i.temperature > cfg_i.temp_warn_limit;
    flags_d.hot   = stage_i.temperature > cfg_i.temp_high_limit;
    flags_d.humid = stage_i.humidity > cfg_i.humid_limit;
    alert_d = (flags_d.water  && !flags_q.water)  ||
              (flags_d.dc_low && !flags_q.dc_low) ||
              (flags_d.ac_low && !flags_q.ac_low) ||
              (flags_d.smoke  && !flags_q.smoke);
    if (ctl_i.advance)              out_valid_d = 1'b1;
    else if (out_valid_q && m_tready) out_valid_d = 1'b0;
    else                            out_valid_d = out_valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      flags_q     <= '0;
    end else begin
      out_valid_q <= out_valid_d;
      if (ctl_i.advance) flags_q <= flags_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.advance) begin
      dcv_q   <= dcv_d;
      acv_q   <= acv_d;
      alert_q <= alert_d;
    end
  end

  assign m_tvalid           = out_valid_q;
  assign result_o.dc_volts  = dcv_q;
  assign result_o.ac_volts  = acv_q;
  assign result_o.flags     = flags_q;
  assign result_o.new_alert = alert_q;

`ifndef SYNTHESIS
  a_adv_needs_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.advance |-> (ctl_i.valid && (!out_valid_q || m_tready)))
    else $error("result register overwritten while full");

  a_alert_has_alarm: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && alert_q) |->
      (flags_q.water || flags_q.dc_low || flags_q.ac_low || flags_q.smoke))
    else $error("new alert without a raised alarm");
`endif

endmodule

// ===== sv/site_power_env_alarm_monitor.sv =====
// Top level of the site power and environment alarm monitor.
//
// Usage:
//   Slave stream (s_t*): one monitoring tick per transfer. Master stream
//   (m_t*): one result per tick, in tick order. Limits are written through
//   cfg_we_i / cfg_idx_i / cfg_wdata_i while no tick is in flight:
//   0 water, 1 DC low, 2 AC low, 3 temp warn, 4 temp high, 5 humidity;
//   other indexes are ignored.
//   A tick passes through the input register, then the result register,
//   before its result shows on m_tdata. Throughput: one tick per cycle
//   while m_tready stays high; the input register and result register form
//   two stages, so a new tick is taken while a finished result still waits.
//   AC samples run through an 8-slot running sum; on the eighth tick the
//   mean is latched and already used for that tick's AC volts.
//   Reset: limits return to their defaults, window sum, slot and mean
//   clear, all alarms off, both stages empty. No clearing pass.
//   Stall: when m_tready is low the result holds, the input register
//   fills, and s_tready drops until the result is taken.
module site_power_env_alarm_monitor (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  // water[9:0] ac[19:10] dc[29:20] smoke[30] temperature[46:31]
  // humidity[56:47], zero above
  input  logic                                  s_tvalid,
  output logic                                  s_tready,
  input  logic [spm_pkg::IN_TDATA_W-1:0]        s_tdata,
  // dc_volts[9:0] ac_volts[18:10] water[19] dc_low[20] ac_low[21]
  // smoke[22] warm[23] hot[24] humid[25] new_alert[26], zero above
  output logic                                  m_tvalid,
  input  logic                                  m_tready,
  output logic [spm_pkg::OUT_TDATA_W-1:0]       m_tdata,
  input  logic                                  cfg_we_i,
  input  logic [spm_pkg::CFG_IDX_W-1:0]         cfg_idx_i,
  input  logic [spm_pkg::CFG_DAT_W-1:0]         cfg_wdata_i
);
  import spm_pkg::*;

  cfg_t        cfg;
  in_item_t    in_item;
  stage_item_t stage_item;
  stage_ctl_t  stage_ctl;
  result_t     result;
  logic        stage_valid;

  // unpack the tick from the stream word
  assign in_item.water_sample = s_tdata[9:0];
  assign in_item.ac_sample    = s_tdata[19:10];
  assign in_item.dc_sample    = s_tdata[29:20];
  assign in_item.smoke_seen   = s_tdata[30];
  assign in_item.temperature  = $signed(s_tdata[46:31]);
  assign in_item.humidity     = s_tdata[56:47];

  // item moves into the result register when that register is empty or its result is taken
  assign stage_ctl.valid   = stage_valid;
  assign stage_ctl.advance = stage_valid && (!m_tvalid || m_tready);

  spm_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  spm_in_stage u_in (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .item_i    (in_item),
    .advance_i (stage_ctl.advance),
    .valid_o   (stage_valid),
    .stage_o   (stage_item)
  );

  spm_eval u_eval (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctl_i    (stage_ctl),
    .stage_i  (stage_item),
    .cfg_i    (cfg),
    .m_tready (m_tready),
    .m_tvalid (m_tvalid),
    .result_o (result)
  );

  assign m_tdata = {5'd0,
                    result.new_alert,
                    result.flags.humid,
                    result.flags.hot,
                    result.flags.warm,
                    result.flags.smoke,
                    result.flags.ac_low,
                    result.flags.dc_low,
                    result.flags.water,
                    result.ac_volts,
                    result.dc_volts};

endmodule
